@@ sv/cnp_pkg.sv @@
// Shared types and constants of the cpio newc stream parser.
// No dependencies; imported by every module of the block.
package cnp_pkg;

  // Result kinds on the output channel.
  localparam logic [2:0] KIND_NAME   = 3'd0;
  localparam logic [2:0] KIND_ENTRY  = 3'd1;
  localparam logic [2:0] KIND_DATA   = 3'd2;
  localparam logic [2:0] KIND_END    = 3'd3;
  localparam logic [2:0] KIND_BADHDR = 3'd4;

  // Entry types reported in a record.
  localparam logic [1:0] ETYPE_FILE  = 2'd0;
  localparam logic [1:0] ETYPE_DIR   = 2'd1;
  localparam logic [1:0] ETYPE_OTHER = 2'd2;

  // Mode field type bits.
  localparam logic [31:0] MODE_TYPE_MASK = 32'o170000;
  localparam logic [31:0] MODE_TYPE_DIR  = 32'o040000;
  localparam logic [31:0] MODE_TYPE_FILE = 32'o100000;
  localparam logic [31:0] MODE_PERM_MASK = 32'o777;

  // Header layout.
  localparam logic [6:0] HDR_LAST     = 7'd109;
  localparam logic [6:0] MAGIC_PREFIX = 7'd5;
  localparam logic [3:0] FIELD_MODE   = 4'd1;
  localparam logic [3:0] FIELD_FSIZE  = 4'd6;
  localparam logic [3:0] FIELD_NSIZE  = 4'd11;
  localparam logic [3:0] TRAILER_LAST = 4'd10;

  // Work left for the back end by one accepted byte: an optional name or
  // data byte, followed by an optional record.
  typedef struct packed {
    logic        byte_vld;
    logic        byte_is_data;
    logic [7:0]  byte_val;
    logic        rec_vld;
    logic [2:0]  rec_kind;
    logic [1:0]  entry_type;
    logic [8:0]  permissions;
    logic [31:0] file_size;
    logic [31:0] name_size;
    logic        is_dot;
  } cnp_run_t;

  // First five characters of the magic, "07070".
  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] c;
    c = idx[0] ? 8'h37 : 8'h30;
    return c;
  endfunction

  // "TRAILER!!!" followed by its terminating zero.
  function automatic logic [7:0] trailer_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h54;
      4'd1:    c = 8'h52;
      4'd2:    c = 8'h41;
      4'd3:    c = 8'h49;
      4'd4:    c = 8'h4C;
      4'd5:    c = 8'h45;
      4'd6:    c = 8'h52;
      4'd7:    c = 8'h21;
      4'd8:    c = 8'h21;
      4'd9:    c = 8'h21;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

@@ sv/cnp_front.sv @@
// Front end of the cpio newc stream parser: accepts archive bytes, tracks
// the entry layout and decodes the header. Depends on cnp_pkg.
module cnp_front import cnp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] byte_in_i,
  input  logic       q_full_i,
  output logic       q_push_o,
  output cnp_run_t   q_data_o
);

  localparam logic [2:0] PH_HEADER   = 3'd0;
  localparam logic [2:0] PH_NAME     = 3'd1;
  localparam logic [2:0] PH_NAME_PAD = 3'd2;
  localparam logic [2:0] PH_DATA     = 3'd3;
  localparam logic [2:0] PH_DATA_PAD = 3'd4;
  localparam logic [2:0] PH_HALT     = 3'd5;

  logic [2:0]  phase_q, phase_d;
  logic [31:0] cnt_q, cnt_d;
  logic [1:0]  off_q, off_d;
  logic        magic_q, magic_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] mode_q, mode_d;
  logic [31:0] size_q, size_d;
  logic [31:0] nsize_q, nsize_d;
  logic        trail_q, trail_d;
  logic        dot_q, dot_d;
  logic        term_q, term_d;

  logic        accept;
  logic        do_finish;
  logic [6:0]  k7;
  logic [6:0]  km6;
  logic [3:0]  field;
  logic [2:0]  digit;
  logic [31:0] hexv;
  logic [31:0] acc_new;
  logic [31:0] type_bits;
  logic [1:0]  etype;
  logic [2:0]  after_phase;
  logic [2:0]  enter_phase;
  logic [31:0] enter_cnt;
  cnp_run_t    run;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  assign k7    = cnt_q[6:0];
  assign km6   = k7 - 7'd6;
  assign field = km6[6:3];
  assign digit = km6[2:0];
  // Any byte that is not a decimal digit is taken as an upper-case hex letter.
  assign hexv  = (byte_in_i >= 8'h30 && byte_in_i <= 8'h39) ?
                 ({24'd0, byte_in_i} - 32'd48) : ({24'd0, byte_in_i} - 32'd55);
  assign acc_new = (digit == 3'd0) ? hexv : ({acc_q[27:0], 4'd0} + hexv);

  assign type_bits = mode_q & MODE_TYPE_MASK;
  always_comb begin
    if (type_bits == MODE_TYPE_FILE) begin
      etype = ETYPE_FILE;
    end else if (type_bits == MODE_TYPE_DIR) begin
      etype = ETYPE_DIR;
    end else begin
      etype = ETYPE_OTHER;
    end
  end

  assign after_phase = (off_d != 2'd0) ? PH_DATA_PAD : PH_HEADER;
  assign enter_phase = (size_q == 32'd0) ? after_phase : PH_DATA;
  assign enter_cnt   = (size_q == 32'd0) ? 32'd0 : size_q;

  always_comb begin
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    off_d     = off_q;
    magic_d   = magic_q;
    acc_d     = acc_q;
    mode_d    = mode_q;
    size_d    = size_q;
    nsize_d   = nsize_q;
    trail_d   = trail_q;
    dot_d     = dot_q;
    term_d    = term_q;
    do_finish = 1'b0;
    run       = '0;

    if (accept && phase_q != PH_HALT) begin
      off_d = off_q + 2'd1;
      unique case (phase_q)
        PH_HEADER: begin
          if (k7 == 7'd0) begin
            magic_d = 1'b1;
          end
          if (k7 < MAGIC_PREFIX) begin
            if (byte_in_i != magic_char(k7[2:0])) begin
              magic_d = 1'b0;
            end
          end else if (k7 == MAGIC_PREFIX) begin
            if (byte_in_i != 8'h31 && byte_in_i != 8'h32) begin
              magic_d = 1'b0;
            end
          end else begin
            acc_d = acc_new;
            if (digit == 3'd7) begin
              if (field == FIELD_MODE) begin
                mode_d = acc_new;
              end else if (field == FIELD_FSIZE) begin
                size_d = acc_new;
              end else if (field == FIELD_NSIZE) begin
                nsize_d = acc_new;
              end
            end
          end
          cnt_d = cnt_q + 32'd1;
          if (k7 == HDR_LAST) begin
            cnt_d   = 32'd0;
            trail_d = 1'b1;
            dot_d   = 1'b1;
            term_d  = 1'b0;
            if (nsize_q == 32'd0) begin
              do_finish = 1'b1;
            end else begin
              phase_d = PH_NAME;
            end
          end
        end
        PH_NAME: begin
          if (!term_q) begin
            if (cnt_q > {28'd0, TRAILER_LAST} ||
                byte_in_i != trailer_char(cnt_q[3:0])) begin
              trail_d = 1'b0;
            end
            if (cnt_q > 32'd1 || byte_in_i != (cnt_q[0] ? 8'h00 : 8'h2E)) begin
              dot_d = 1'b0;
            end
            if (byte_in_i == 8'h00) begin
              term_d = 1'b1;
            end
          end
          run.byte_vld = 1'b1;
          run.byte_val = byte_in_i;
          cnt_d = cnt_q + 32'd1;
          if (cnt_d == nsize_q) begin
            do_finish = 1'b1;
          end
        end
        PH_NAME_PAD: begin
          if (off_d == 2'd0) begin
            phase_d = enter_phase;
            cnt_d   = enter_cnt;
          end
        end
        PH_DATA: begin
          if (etype == ETYPE_FILE) begin
            run.byte_vld     = 1'b1;
            run.byte_is_data = 1'b1;
            run.byte_val     = byte_in_i;
          end
          cnt_d = cnt_q - 32'd1;
          if (cnt_q == 32'd1) begin
            phase_d = after_phase;
            cnt_d   = 32'd0;
          end
        end
        PH_DATA_PAD: begin
          if (off_d == 2'd0) begin
            phase_d = PH_HEADER;
            cnt_d   = 32'd0;
          end
        end
        default: begin
          phase_d = PH_HALT;
        end
      endcase

      // End of the name: the trailer wins over a bad magic.
      if (do_finish) begin
        run.rec_vld = 1'b1;
        if (trail_d && term_d) begin
          run.rec_kind = KIND_END;
          phase_d      = PH_HALT;
        end else if (!magic_d) begin
          run.rec_kind = KIND_BADHDR;
          phase_d      = PH_HALT;
        end else begin
          run.rec_kind    = KIND_ENTRY;
          run.entry_type  = etype;
          run.permissions = 9'(mode_q & MODE_PERM_MASK);
          run.file_size   = size_q;
          run.name_size   = nsize_q;
          run.is_dot      = dot_d && term_d;
          if (off_d != 2'd0) begin
            phase_d = PH_NAME_PAD;
          end else begin
            phase_d = enter_phase;
            cnt_d   = enter_cnt;
          end
        end
      end
    end
  end

  assign q_push_o = accept && (run.byte_vld || run.rec_vld);
  assign q_data_o = run;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEADER;
      cnt_q   <= '0;
      off_q   <= '0;
      magic_q <= 1'b1;
      acc_q   <= '0;
      mode_q  <= '0;
      size_q  <= '0;
      nsize_q <= '0;
      trail_q <= 1'b1;
      dot_q   <= 1'b1;
      term_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      off_q   <= off_d;
      magic_q <= magic_d;
      acc_q   <= acc_d;
      mode_q  <= mode_d;
      size_q  <= size_d;
      nsize_q <= nsize_d;
      trail_q <= trail_d;
      dot_q   <= dot_d;
      term_q  <= term_d;
    end
  end

  a_halt_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HALT |-> !q_push_o)
    else $error("front produced work after halting");

  a_header_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_HEADER |-> cnt_q <= {25'd0, HDR_LAST})
    else $error("header counter ran past the header");

endmodule

@@ sv/cnp_queue.sv @@
// Short queue of per-byte work between the front and back ends of the
// cpio newc stream parser. Depends on cnp_pkg.
module cnp_queue import cnp_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  cnp_run_t push_data_i,
  output logic     full_o,
  input  logic     pop_i,
  output logic     empty_o,
  output cnp_run_t head_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  cnp_run_t        mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push;
  logic            do_pop;

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_cnt_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntFull)
    else $error("queue fill count exceeds its depth");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o)
    else $error("work pushed into a full queue");

endmodule

@@ sv/cnp_back.sv @@
// Back end of the cpio newc stream parser: turns queued work into result
// items and holds them in the output register. Depends on cnp_pkg.
module cnp_back import cnp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        q_empty_i,
  input  cnp_run_t    q_head_i,
  output logic        q_pop_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  byte_value_o,
  output logic [1:0]  entry_type_o,
  output logic [8:0]  permissions_o,
  output logic [31:0] file_size_o,
  output logic [31:0] name_size_o,
  output logic        is_dot_entry_o,
  output logic        last_of_run_o
);

  logic        valid_q, valid_d;
  logic        second_q, second_d;
  logic [2:0]  kind_q, kind_d;
  logic [7:0]  bval_q, bval_d;
  logic [1:0]  etype_q, etype_d;
  logic [8:0]  perm_q, perm_d;
  logic [31:0] fsize_q, fsize_d;
  logic [31:0] nsize_q, nsize_d;
  logic        dot_q, dot_d;
  logic        last_q, last_d;
  logic        load;

  assign load = !valid_q || out_ready_i;

  always_comb begin
    valid_d  = valid_q;
    second_d = second_q;
    kind_d   = kind_q;
    bval_d   = bval_q;
    etype_d  = etype_q;
    perm_d   = perm_q;
    fsize_d  = fsize_q;
    nsize_d  = nsize_q;
    dot_d    = dot_q;
    last_d   = last_q;
    q_pop_o  = 1'b0;
    if (load) begin
      valid_d = !q_empty_i;
      if (!q_empty_i) begin
        if (q_head_i.byte_vld && !second_q) begin
          // The byte goes first; a record behind it keeps the work queued.
          kind_d   = q_head_i.byte_is_data ? KIND_DATA : KIND_NAME;
          bval_d   = q_head_i.byte_val;
          etype_d  = '0;
          perm_d   = '0;
          fsize_d  = '0;
          nsize_d  = '0;
          dot_d    = 1'b0;
          last_d   = !q_head_i.rec_vld;
          second_d = q_head_i.rec_vld;
          q_pop_o  = !q_head_i.rec_vld;
        end else begin
          kind_d   = q_head_i.rec_kind;
          bval_d   = '0;
          etype_d  = q_head_i.entry_type;
          perm_d   = q_head_i.permissions;
          fsize_d  = q_head_i.file_size;
          nsize_d  = q_head_i.name_size;
          dot_d    = q_head_i.is_dot;
          last_d   = 1'b1;
          second_d = 1'b0;
          q_pop_o  = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      second_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      second_q <= second_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    bval_q  <= bval_d;
    etype_q <= etype_d;
    perm_q  <= perm_d;
    fsize_q <= fsize_d;
    nsize_q <= nsize_d;
    dot_q   <= dot_d;
    last_q  <= last_d;
  end

  assign out_valid_o    = valid_q;
  assign kind_o         = kind_q;
  assign byte_value_o   = bval_q;
  assign entry_type_o   = etype_q;
  assign permissions_o  = perm_q;
  assign file_size_o    = fsize_q;
  assign name_size_o    = nsize_q;
  assign is_dot_entry_o = dot_q;
  assign last_of_run_o  = last_q;

  a_second_queued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> !q_empty_i)
    else $error("record pending but its work left the queue");

  a_second_after_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    second_q |-> valid_q && !last_q)
    else $error("record pending without an unfinished byte shown");

endmodule

@@ sv/cpio_newc_stream_parser.sv @@
// Top level of the cpio newc stream parser: front end, work queue and
// back end. Depends on cnp_pkg, cnp_front, cnp_queue and cnp_back.
//
//   channel | signals                          | direction
//   input   | in_valid_i, in_ready_o, byte_in_i | one archive byte per item
//   output  | out_valid_o, out_ready_i, fields  | one result per item
//
// One archive byte is accepted per cycle while the work queue has room.
// A byte that ends a name gives two results, which the output register
// delivers one after the other; this back end port sets the result rate.
// Bytes that give no result never enter the queue.
// Reset clears all control state at once; no clearing pass is needed.
// A stalled output fills the QueueDepth-entry queue before input stalls.
module cpio_newc_stream_parser import cnp_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  byte_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  byte_value_o,
  output logic [1:0]  entry_type_o,
  output logic [8:0]  permissions_o,
  output logic [31:0] file_size_o,
  output logic [31:0] name_size_o,
  output logic        is_dot_entry_o,
  output logic        last_of_run_o
);

  logic     q_full;
  logic     q_push;
  logic     q_pop;
  logic     q_empty;
  cnp_run_t q_in;
  cnp_run_t q_head;

  cnp_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .byte_in_i  (byte_in_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_in)
  );

  cnp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_data_i (q_in),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .empty_o     (q_empty),
    .head_o      (q_head)
  );

  cnp_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .byte_value_o   (byte_value_o),
    .entry_type_o   (entry_type_o),
    .permissions_o  (permissions_o),
    .file_size_o    (file_size_o),
    .name_size_o    (name_size_o),
    .is_dot_entry_o (is_dot_entry_o),
    .last_of_run_o  (last_of_run_o)
  );

endmodule

@@ verif/cpio_newc_stream_parser_tb.sv @@
// Self-checking testbench for the cpio newc stream parser.
// Depends on cnp_pkg and cpio_newc_stream_parser; drives archive entries and
// checks every result item against a behavioural parser written here.
module cpio_newc_stream_parser_tb;
  import cnp_pkg::*;

  localparam int HDR_BYTES   = int'(HDR_LAST) + 1;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RAND_ENTRIES = 2;
  localparam int QUIET_TAIL   = 1;
  localparam logic [39:0] MAGIC_TXT   = "07070";
  localparam logic [79:0] TRAILER_TXT = "TRAILER!!!";

  typedef enum logic [2:0] {
    ST_HEADER, ST_NAME, ST_NAME_PAD, ST_DATA, ST_DATA_PAD, ST_HALT
  } parse_state_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  bval;
    logic [1:0]  etype;
    logic [8:0]  perm;
    logic [31:0] fsize;
    logic [31:0] nsize;
    logic        dot;
    logic        last;
  } result_t;

  // One directed archive entry. Name bytes past name_len are a zero and then
  // a filler tail; typed rows carry the record that can be read off by eye.
  typedef struct packed {
    logic [47:0]  magic;
    logic [63:0]  mode_txt;
    logic [31:0]  fsize;
    logic [31:0]  nsize;
    logic [127:0] name_txt;
    logic [4:0]   name_len;
    logic [7:0]   fill;
    logic         typed;
    result_t      rec;
  } entry_row_t;

  localparam entry_row_t ENTRY_ROWS [3] = '{
    '{"070702", "000041C0", 32'd3, 32'd4, ".", 5'd1, 8'h30, 1'b1,
      '{KIND_ENTRY, 8'h00, ETYPE_DIR, 9'o700, 32'd3, 32'd4, 1'b1, 1'b1}},
    '{"070701", "FFFFFFFF", 32'd2, 32'd0, 128'h0, 5'd0, 8'h30, 1'b1,
      '{KIND_ENTRY, 8'h00, ETYPE_OTHER, 9'o777, 32'd2, 32'd0, 1'b0, 1'b1}},
    '{"070701", "000081a4", 32'd7, 32'd12, "TRAILER!!!X", 5'd11, 8'hFF, 1'b0, '0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready_o;
  logic [7:0]  byte_in = 8'h00;
  logic        out_valid_o;
  logic        out_ready = 1'b0;
  logic [2:0]  kind_o;
  logic [7:0]  byte_value_o;
  logic [1:0]  entry_type_o;
  logic [8:0]  permissions_o;
  logic [31:0] file_size_o;
  logic [31:0] name_size_o;
  logic        is_dot_entry_o;
  logic        last_of_run_o;

  // Parser state mirrored by the predictor.
  parse_state_e st;
  logic [31:0]  st_cnt, acc, mode_r, fsize_r, nsize_r;
  logic [1:0]   align;
  logic         magic_good, trl_ok, dot_ok, name_done;

  result_t     pending_results[$];
  result_t     step_results[$];
  logic [7:0]  name_buf[$];
  result_t     typed_rec;
  bit          typed_valid = 1'b0;
  bit          idle_on = 1'b1;
  int          errors = 0;
  int          cycle_cnt = 0;
  int          stall_left = 0;
  bit          took = 1'b0;
  result_t     seen;

  cpio_newc_stream_parser i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .byte_in_i      (byte_in),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .kind_o         (kind_o),
    .byte_value_o   (byte_value_o),
    .entry_type_o   (entry_type_o),
    .permissions_o  (permissions_o),
    .file_size_o    (file_size_o),
    .name_size_o    (name_size_o),
    .is_dot_entry_o (is_dot_entry_o),
    .last_of_run_o  (last_of_run_o)
  );

  always #2 clk_i = ~clk_i;

  function automatic logic [1:0] type_of(input logic [31:0] m);
    if ((m & MODE_TYPE_MASK) == MODE_TYPE_FILE) return ETYPE_FILE;
    if ((m & MODE_TYPE_MASK) == MODE_TYPE_DIR) return ETYPE_DIR;
    return ETYPE_OTHER;
  endfunction

  function automatic void clear_parser();
    st = ST_HEADER;
    st_cnt = '0;
    align = '0;
    magic_good = 1'b1;
    acc = '0;
    mode_r = '0;
    fsize_r = '0;
    nsize_r = '0;
    trl_ok = 1'b1;
    dot_ok = 1'b1;
    name_done = 1'b0;
  endfunction

  function automatic void leave_data();
    if (align != 0) begin
      st = ST_DATA_PAD;
    end else begin
      st = ST_HEADER;
      st_cnt = '0;
    end
  endfunction

  function automatic void enter_data();
    if (fsize_r == 0) begin
      leave_data();
    end else begin
      st = ST_DATA;
      st_cnt = fsize_r;
    end
  endfunction

  function automatic void emit_byte(input logic [2:0] kind, input logic [7:0] b);
    result_t r;
    r = '0;
    r.kind = kind;
    r.bval = b;
    step_results.push_back(r);
  endfunction

  // End of a name: the trailer wins over a bad magic, which wins over a record.
  function automatic void close_name();
    result_t r;
    r = '0;
    if (trl_ok && name_done) begin
      st = ST_HALT;
      r.kind = KIND_END;
    end else if (!magic_good) begin
      st = ST_HALT;
      r.kind = KIND_BADHDR;
    end else begin
      r.kind  = KIND_ENTRY;
      r.etype = type_of(mode_r);
      r.perm  = mode_r[8:0];
      r.fsize = fsize_r;
      r.nsize = nsize_r;
      r.dot   = dot_ok && name_done;
      if (typed_valid) begin
        r = typed_rec;
        typed_valid = 1'b0;
      end
      if (align != 0) st = ST_NAME_PAD;
      else enter_data();
    end
    step_results.push_back(r);
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    logic [31:0] k, v;
    logic [3:0]  fld;
    logic [2:0]  dig;
    step_results.delete();
    if (st == ST_HALT) return;
    align = align + 2'd1;
    case (st)
      ST_HEADER: begin
        k = st_cnt;
        if (k == 0) magic_good = 1'b1;
        if (k < 5) begin
          if (b != MAGIC_TXT[8*(4-k) +: 8]) magic_good = 1'b0;
        end else if (k == 5) begin
          if (b != 8'h31 && b != 8'h32) magic_good = 1'b0;
        end else if (k < HDR_BYTES) begin
          fld = 4'((k - 6) >> 3);
          dig = 3'((k - 6) & 7);
          // Anything that is not a decimal digit counts from 'A', wrapping.
          if (b >= 8'h30 && b <= 8'h39) v = {24'd0, b} - 32'h30;
          else v = {24'd0, b} - 32'h41 + 32'd10;
          if (dig == 0) acc = v;
          else acc = (acc << 4) + v;
          if (dig == 7) begin
            if (fld == FIELD_MODE) mode_r = acc;
            else if (fld == FIELD_FSIZE) fsize_r = acc;
            else if (fld == FIELD_NSIZE) nsize_r = acc;
          end
        end
        st_cnt = k + 1;
        if (st_cnt >= HDR_BYTES) begin
          st_cnt = '0;
          trl_ok = 1'b1;
          dot_ok = 1'b1;
          name_done = 1'b0;
          if (nsize_r == 0) close_name();
          else st = ST_NAME;
        end
      end
      ST_NAME: begin
        k = st_cnt;
        if (!name_done) begin
          if (k > 10) trl_ok = 1'b0;
          else if (k == 10) begin
            if (b != 8'h00) trl_ok = 1'b0;
          end else if (b != TRAILER_TXT[8*(9-k) +: 8]) trl_ok = 1'b0;
          if (k > 1) dot_ok = 1'b0;
          else if (b != ((k == 0) ? 8'h2E : 8'h00)) dot_ok = 1'b0;
          if (b == 8'h00) name_done = 1'b1;
        end
        emit_byte(KIND_NAME, b);
        st_cnt = k + 1;
        if (st_cnt == nsize_r) close_name();
      end
      ST_NAME_PAD: begin
        if (align == 0) enter_data();
      end
      ST_DATA: begin
        if (type_of(mode_r) == ETYPE_FILE) emit_byte(KIND_DATA, b);
        st_cnt = st_cnt - 1;
        if (st_cnt == 0) leave_data();
      end
      default: begin
        if (align == 0) begin
          st = ST_HEADER;
          st_cnt = '0;
        end
      end
    endcase
    if (step_results.size() > 0) step_results[step_results.size()-1].last = 1'b1;
    foreach (step_results[i]) pending_results.push_back(step_results[i]);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 10) return 8'h30 + 8'(nib);
    return 8'h41 + 8'(nib) - 8'd10;
  endfunction

  // Eight hex digits, with some letters turned to lowercase when mixed.
  function automatic logic [63:0] hex_text(input logic [31:0] v, input bit mixed);
    logic [63:0] t;
    logic [7:0]  c;
    t = '0;
    for (int d = 0; d < 8; d++) begin
      c = hex_char(v[4*(7-d) +: 4]);
      if (mixed && c > 8'h39 && $urandom_range(0, 2) == 0) c = c + 8'h20;
      t = {t[55:0], c};
    end
    return t;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("kind=%0d byte=%02h type=%0d perm=%03o fsize=%0d nsize=%0d dot=%0d last=%0d",
                     r.kind, r.bval, r.etype, r.perm, r.fsize, r.nsize, r.dot, r.last);
  endfunction

  // Offers one byte; returns just after the edge at which it is accepted.
  task automatic push_byte(input logic [7:0] b);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    parse_byte(b);
    in_valid <= 1'b1;
    byte_in  <= b;
    @(negedge clk_i);
    while (!in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
  endtask

  // Header, name from name_buf, and when whole is set the padding and data.
  task automatic send_entry(input logic [47:0] magic, input logic [63:0] mode_txt,
                            input logic [31:0] fsize, input logic [31:0] nsize,
                            input bit noisy, input logic [7:0] fill_chr, input bit whole);
    logic [7:0] c;
    int         pad;
    for (int j = 0; j < 6; j++) push_byte(magic[8*(5-j) +: 8]);
    for (int f = 0; f < 13; f++) begin
      for (int d = 0; d < 8; d++) begin
        if (f == FIELD_MODE) c = mode_txt[8*(7-d) +: 8];
        else if (f == FIELD_FSIZE) c = hex_char(fsize[4*(7-d) +: 4]);
        else if (f == FIELD_NSIZE) c = hex_char(nsize[4*(7-d) +: 4]);
        else if (!noisy) c = fill_chr;
        else if ($urandom_range(0, 1) == 1) c = hex_char(4'($urandom_range(0, 15)));
        else c = 8'($urandom_range(0, 255));
        push_byte(c);
      end
    end
    for (int j = 0; j < int'(nsize); j++) push_byte(name_buf[j]);
    if (whole) begin
      pad = (4 - (HDR_BYTES + int'(nsize)) % 4) % 4;
      repeat (pad) push_byte(8'($urandom_range(0, 255)));
      for (int j = 0; j < int'(fsize); j++) begin
        if (noisy) c = 8'($urandom_range(0, 255));
        else if (j == 0) c = 8'h00;
        else if (j == 1) c = 8'hFF;
        else c = 8'(j * 41 + 1);
        push_byte(c);
      end
      pad = (4 - int'(fsize) % 4) % 4;
      repeat (pad) push_byte(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic send_random_entry();
    logic [31:0] mode_num, fsize, nsize;
    logic [63:0] mode_txt;
    logic [47:0] magic;
    int          zpos;
    magic = {MAGIC_TXT, ($urandom_range(0, 1) == 1) ? 8'h32 : 8'h31};
    mode_txt = '0;
    case ($urandom_range(0, 4))
      0, 1: mode_num = MODE_TYPE_FILE;
      2: mode_num = MODE_TYPE_DIR;
      3: begin
        mode_num = 32'($urandom_range(0, 15)) << 12;
        if (mode_num == MODE_TYPE_FILE || mode_num == MODE_TYPE_DIR) mode_num = 32'o120000;
      end
      default: mode_num = '1;
    endcase
    if (mode_num == '1) begin
      // Raw bytes in the mode field: the decode wraps to something odd.
      for (int d = 0; d < 8; d++) mode_txt = {mode_txt[55:0], 8'($urandom_range(0, 255))};
    end else begin
      mode_num = mode_num | ($urandom() & 32'hFFFF0FFF);
      mode_txt = hex_text(mode_num, $urandom_range(0, 7) == 0);
    end
    fsize = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 9);
    name_buf.delete();
    case ($urandom_range(0, 7))
      0, 1, 2: begin
        nsize = $urandom_range(1, 12);
        for (int j = 1; j < int'(nsize); j++) name_buf.push_back(8'($urandom_range(1, 255)));
        name_buf.push_back(8'h00);
      end
      3: begin
        nsize = $urandom_range(2, 5);
        name_buf.push_back(8'h2E);
        name_buf.push_back(8'h00);
        for (int j = 2; j < int'(nsize); j++) name_buf.push_back(8'($urandom_range(0, 255)));
      end
      4: begin
        nsize = $urandom_range(1, 8);
        for (int j = 0; j < int'(nsize); j++) name_buf.push_back(8'($urandom_range(1, 255)));
      end
      5: begin
        nsize = $urandom_range(2, 12);
        zpos = $urandom_range(0, int'(nsize) - 2);
        for (int j = 0; j < int'(nsize); j++) begin
          if (j < zpos) name_buf.push_back(8'($urandom_range(1, 255)));
          else if (j == zpos) name_buf.push_back(8'h00);
          else name_buf.push_back(8'($urandom_range(0, 255)));
        end
      end
      6: begin
        // The trailer name without its terminator is an ordinary entry.
        nsize = $urandom_range(10, 11);
        for (int j = 0; j < 10; j++) name_buf.push_back(TRAILER_TXT[8*(9-j) +: 8]);
        if (nsize == 11) name_buf.push_back(8'($urandom_range(1, 255)));
      end
      default: nsize = '0;
    endcase
    send_entry(magic, mode_txt, fsize, nsize, $urandom_range(0, 3) != 0,
               hex_char(4'($urandom_range(0, 15))), 1'b1);
  endtask

  // Ends the archive with a trailer (good or bad magic) or a bad header,
  // then feeds a few bytes that the halted block must swallow.
  task automatic send_closing_entry();
    logic [47:0] magic;
    logic [31:0] nsize;
    int          sel, pos;
    magic = {MAGIC_TXT, 8'h31};
    sel = $urandom_range(0, 3);
    if (sel != 0) begin
      pos = $urandom_range(0, 5);
      magic[8*(5-pos) +: 8] = magic[8*(5-pos) +: 8] ^ (8'h01 << $urandom_range(0, 7));
    end
    name_buf.delete();
    if (sel < 2) begin
      nsize = ($urandom_range(0, 1) == 1) ? 32'd14 : 32'd11;
      for (int j = 0; j < 10; j++) name_buf.push_back(TRAILER_TXT[8*(9-j) +: 8]);
      name_buf.push_back(8'h00);
      for (int j = 11; j < int'(nsize); j++) name_buf.push_back(8'($urandom_range(0, 255)));
    end else if (sel == 2) begin
      nsize = 32'd4;
      for (int j = 0; j < 3; j++) name_buf.push_back(8'($urandom_range(1, 255)));
      name_buf.push_back(8'h00);
    end else begin
      nsize = '0;
    end
    send_entry(magic, "000081A4", 32'd0, nsize, 1'b1, 8'h30, 1'b0);
    repeat (6) push_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  // Results are sampled mid-cycle and checked at the edge that accepts them.
  always @(negedge clk_i) begin
    took = out_valid_o && out_ready;
    seen = {kind_o, byte_value_o, entry_type_o, permissions_o, file_size_o, name_size_o,
            is_dot_entry_o, last_of_run_o};
  end

  always @(posedge clk_i) begin
    result_t want;
    if (took) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %s", $time, show(seen));
      end else begin
        want = pending_results.pop_front();
        if (seen !== want) begin
          errors++;
          $display("%0t: result mismatch, expected %s, actual %s", $time, show(want),
                   show(seen));
        end
      end
    end
    if (stall_left == 0 && idle_on && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 5);
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin : stimulus
    entry_row_t row;
    clear_parser();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (ENTRY_ROWS[r]) begin
      row = ENTRY_ROWS[r];
      name_buf.delete();
      for (int j = 0; j < int'(row.nsize); j++) begin
        if (j < int'(row.name_len)) name_buf.push_back(row.name_txt[8*(int'(row.name_len)-1-j) +: 8]);
        else if (j == int'(row.name_len)) name_buf.push_back(8'h00);
        else name_buf.push_back(8'(8'hA0 + j));
      end
      typed_rec = row.rec;
      typed_valid = row.typed;
      send_entry(row.magic, row.mode_txt, row.fsize, row.nsize, 1'b0, row.fill, 1'b1);
    end

    // Let the output side run dry before the random archive carries on.
    wait_for_results();
    @(posedge clk_i);

    for (int e = 0; e < RAND_ENTRIES; e++) begin
      if (e >= RAND_ENTRIES - QUIET_TAIL) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 3) != 0);
      send_random_entry();
    end
    send_closing_entry();

    wait_for_results();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

@@ cpio_newc_stream_parser.f @@
sv/cnp_pkg.sv
sv/cnp_front.sv
sv/cnp_queue.sv
sv/cnp_back.sv
sv/cpio_newc_stream_parser.sv
verif/cpio_newc_stream_parser_tb.sv
